@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the Otsu binarizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTSU_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("otsu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OTSU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("otsu assertion failed");

`endif

@@ rtl/core/otsu_pkg.sv @@
// Shared types and constants for the Otsu threshold binarizer.
`timescale 1ns / 1ps
`default_nettype none
package otsu_pkg;

  localparam int COUNT_BITS_DEF = 20;

  localparam logic       OP_ACC  = 1'b0;
  localparam logic       OP_BIN  = 1'b1;
  localparam logic [7:0] PIX_HI  = 8'hFF;
  localparam logic [7:0] PIX_LO  = 8'h00;
  localparam logic [7:0] BIN_LAST = 8'hFF;

  typedef enum logic [3:0] {
    S_CLR,
    S_ACC,
    S_SUM,
    S_SUMEND,
    S_RD,
    S_UPD,
    S_CHK,
    S_MGO,
    S_MWAIT,
    S_NEXT,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_LHS,
    MS_RHS,
    MS_D2,
    MS_PROD,
    MS_X,
    MS_Y
  } mstep_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } hist_wr_t;

endpackage
`default_nettype wire

@@ rtl/core/otsu_in_if.sv @@
// Input request channel: opcode, luma and last.
`timescale 1ns / 1ps
`default_nettype none
interface otsu_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] luma;
  logic       last;
  modport source (output valid, opcode, luma, last, input ready);
  modport sink   (input valid, opcode, luma, last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/otsu_out_if.sv @@
// Result request channel: binarized pixel or new threshold.
`timescale 1ns / 1ps
`default_nettype none
interface otsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic [7:0] threshold;
  logic       is_threshold;
  modport source (output valid, pixel_out, threshold, is_threshold, input ready);
  modport sink   (input valid, pixel_out, threshold, is_threshold, output ready);
endinterface
`default_nettype wire

@@ rtl/core/otsu_threshold_binarizer.sv @@
// Top level of the Otsu threshold binarizer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Accumulate requests (opcode 0) and binarize requests (opcode 1) are taken one
// per cycle while the result register is free; accumulate counts go through a
// read-modify-write of the histogram memory with forwarding, so equal luma
// values back to back are counted correctly. An accumulate request with last
// set starts the threshold sweep and no request is taken until it reports:
// one pass sums the histogram, then each bin is read, counted and cleared, and
// takes up to six bit-serial multiplies in the shared multiplier, each one
// stepping through the significant bits of its multiplier operand (at most
// 2*COUNT_BITS+24 bits). The sweep clears the histogram as it reads it. After
// reset a clearing pass runs before the first request is taken.
module otsu_threshold_binarizer
  import otsu_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  otsu_in_if.sink   in_ch,
  otsu_out_if.source out_ch
);

  localparam int N_W  = COUNT_BITS + 8;
  localparam int S_W  = COUNT_BITS + 16;
  localparam int D_W  = N_W + S_W;
  localparam int D2_W = 2 * D_W;
  localparam int PR_W = 2 * N_W;
  localparam int P_W  = D2_W + PR_W;
  localparam int M_W  = D_W;

  state_t state_r, state_nxt;
  mstep_t step_r, step_nxt;
  logic [7:0] t_r;

  // accumulate pipeline and last-write forwarding
  logic                  a_v_r, a_last_r;
  logic [7:0]            a_addr_r;
  logic                  lw_v_r;
  logic [7:0]            lw_addr_r;
  logic [COUNT_BITS-1:0] lw_data_r;
  logic [COUNT_BITS-1:0] acc_old, acc_new;

  logic       sv_r;
  logic [7:0] sidx_r;

  logic [N_W-1:0]  n_all_r, n0_r, n1;
  logic [S_W-1:0]  s_all_r, s0_r, s1;
  logic            have_r;
  logic [7:0]      chosen_r, best_thr_r;
  logic [D_W-1:0]  lhs_r, d_r;
  logic [D2_W-1:0] d2_r, best_d2_r;
  logic [PR_W-1:0] prod_r, best_prod_r;
  logic [P_W-1:0]  x_r;

  hist_wr_t              wr;
  logic [COUNT_BITS-1:0] wr_data, rd_data;
  logic [7:0]            rd_addr;

  logic           mul_start, mul_done;
  logic [P_W-1:0] mul_a, mul_prod;
  logic [M_W-1:0] mul_b;

  logic       out_valid_r, out_is_thr_r;
  logic [7:0] out_pix_r, out_thr_r;
  logic       out_free, in_acc;

  otsu_hist_mem #(.COUNT_BITS(COUNT_BITS)) u_mem (
    .clk     (clk),
    .wr      (wr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  otsu_mul #(.P_W(P_W), .M_W(M_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_ACC) && !(a_v_r && a_last_r) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign acc_old = (lw_v_r && (lw_addr_r == a_addr_r)) ? lw_data_r : rd_data;
  assign acc_new = (&acc_old) ? acc_old : acc_old + 1'b1;

  assign n1 = n_all_r - n0_r;
  assign s1 = s_all_r - s0_r;

  always_comb begin
    unique case (step_r)
      MS_LHS:  begin mul_a = P_W'(s1);        mul_b = M_W'(n0_r);        end
      MS_RHS:  begin mul_a = P_W'(s0_r);      mul_b = M_W'(n1);          end
      MS_D2:   begin mul_a = P_W'(d_r);       mul_b = d_r;               end
      MS_PROD: begin mul_a = P_W'(n0_r);      mul_b = M_W'(n1);          end
      MS_X:    begin mul_a = P_W'(d2_r);      mul_b = M_W'(best_prod_r); end
      MS_Y:    begin mul_a = P_W'(best_d2_r); mul_b = M_W'(prod_r);      end
      default: begin mul_a = '0;              mul_b = '0;                end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rd_addr   = t_r;
    wr        = '0;
    wr_data   = '0;
    mul_start = 1'b0;
    unique case (state_r)
      S_CLR: begin
        wr.en   = 1'b1;
        wr.addr = t_r;
        if (t_r == BIN_LAST) state_nxt = S_ACC;
      end
      S_ACC: begin
        rd_addr = in_ch.luma;
        if (a_v_r) begin
          wr.en   = 1'b1;
          wr.addr = a_addr_r;
          wr_data = acc_new;
          if (a_last_r) state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (t_r == BIN_LAST) state_nxt = S_SUMEND;
      end
      S_SUMEND: state_nxt = S_RD;
      S_RD:     state_nxt = S_UPD;
      S_UPD: begin
        wr.en     = 1'b1;
        wr.addr   = t_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (n0_r == '0 || n1 == '0) begin
          state_nxt = S_NEXT;
        end else begin
          step_nxt  = MS_LHS;
          state_nxt = S_MGO;
        end
      end
      S_MGO: begin
        mul_start = 1'b1;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (mul_done) begin
          unique case (step_r)
            MS_LHS:  begin step_nxt = MS_RHS;  state_nxt = S_MGO; end
            MS_RHS:  begin step_nxt = MS_D2;   state_nxt = S_MGO; end
            MS_D2:   begin step_nxt = MS_PROD; state_nxt = S_MGO; end
            MS_PROD: begin
              if (have_r) begin
                step_nxt  = MS_X;
                state_nxt = S_MGO;
              end else begin
                state_nxt = S_NEXT;
              end
            end
            MS_X:    begin step_nxt = MS_Y;    state_nxt = S_MGO; end
            MS_Y:    state_nxt = S_NEXT;
            default: state_nxt = S_NEXT;
          endcase
        end
      end
      S_NEXT: state_nxt = (t_r == BIN_LAST) ? S_OUT : S_RD;
      S_OUT: begin
        if (out_free) state_nxt = S_ACC;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      step_r      <= MS_LHS;
      t_r         <= '0;
      a_v_r       <= 1'b0;
      lw_v_r      <= 1'b0;
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      best_thr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sv_r    <= (state_r == S_SUM);
      lw_v_r  <= wr.en;
      a_v_r   <= in_acc && (in_ch.opcode == OP_ACC);
      if (state_r == S_CLR || state_r == S_SUM || state_r == S_NEXT) begin
        t_r <= t_r + 1'b1;
      end else if (state_r == S_ACC) begin
        t_r <= '0;
      end
      if (state_r == S_OUT && out_free) begin
        best_thr_r  <= have_r ? chosen_r : '0;
        out_valid_r <= 1'b1;
      end else if (in_acc && (in_ch.opcode == OP_BIN)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    a_addr_r  <= in_ch.luma;
    a_last_r  <= in_ch.last;
    lw_addr_r <= wr.addr;
    lw_data_r <= wr_data;
    sidx_r    <= t_r;
    if (state_r == S_ACC) begin
      n_all_r <= '0;
      s_all_r <= '0;
      n0_r    <= '0;
      s0_r    <= '0;
      have_r  <= 1'b0;
    end else if (sv_r) begin
      n_all_r <= n_all_r + N_W'(rd_data);
      s_all_r <= s_all_r + S_W'(sidx_r) * S_W'(rd_data);
    end else if (state_r == S_UPD) begin
      n0_r <= n0_r + N_W'(rd_data);
      s0_r <= s0_r + S_W'(t_r) * S_W'(rd_data);
    end
    if (state_r == S_MWAIT && mul_done) begin
      unique case (step_r)
        MS_LHS:  lhs_r <= mul_prod[D_W-1:0];
        MS_RHS:  d_r   <= lhs_r - mul_prod[D_W-1:0];
        MS_D2:   d2_r  <= mul_prod[D2_W-1:0];
        MS_PROD: begin
          prod_r <= mul_prod[PR_W-1:0];
          if (!have_r) begin
            have_r      <= 1'b1;
            best_d2_r   <= d2_r;
            best_prod_r <= mul_prod[PR_W-1:0];
            chosen_r    <= t_r;
          end
        end
        MS_X:    x_r <= mul_prod;
        MS_Y: begin
          if (x_r > mul_prod) begin
            best_d2_r   <= d2_r;
            best_prod_r <= prod_r;
            chosen_r    <= t_r;
          end
        end
        default: ;
      endcase
    end
    if (state_r == S_OUT && out_free) begin
      out_pix_r    <= PIX_LO;
      out_thr_r    <= have_r ? chosen_r : '0;
      out_is_thr_r <= 1'b1;
    end else if (in_acc && (in_ch.opcode == OP_BIN)) begin
      out_pix_r    <= (in_ch.luma < best_thr_r) ? PIX_LO : PIX_HI;
      out_thr_r    <= best_thr_r;
      out_is_thr_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_out    = out_pix_r;
  assign out_ch.threshold    = out_thr_r;
  assign out_ch.is_threshold = out_is_thr_r;

  `OTSU_ASSERT_NEXT(a_last_starts_sweep, clk, rst_n,
    state_r == S_ACC && a_v_r && a_last_r, state_r == S_SUM)
  `OTSU_ASSERT_NOW(a_sum_window, clk, rst_n,
    sv_r, state_r == S_SUM || state_r == S_SUMEND)
  `OTSU_ASSERT_NEXT(a_thr_reported, clk, rst_n,
    state_r == S_OUT && out_free, out_valid_r && out_is_thr_r)

endmodule
`default_nettype wire

@@ rtl/core/otsu_hist_mem.sv @@
// 256-bin histogram memory, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module otsu_hist_mem
  import otsu_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire hist_wr_t              wr,
  input  wire logic [COUNT_BITS-1:0] wr_data,
  input  wire logic [7:0]            rd_addr,
  output logic      [COUNT_BITS-1:0] rd_data
);

  logic [COUNT_BITS-1:0] mem [256];
  logic [COUNT_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/core/otsu_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, early exit on zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module otsu_mul
  import otsu_pkg::*;
#(
  parameter int P_W = 4 * COUNT_BITS_DEF + 48,
  parameter int M_W = 2 * COUNT_BITS_DEF + 24
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [P_W-1:0] a,
  input  wire logic [M_W-1:0] b,
  output logic      [P_W-1:0] prod,
  output logic                done
);

  logic           busy_r;
  logic           done_r;
  logic [P_W-1:0] acc_r;
  logic [P_W-1:0] mcand_r;
  logic [M_W-1:0] mplr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (mplr_r[M_W-1:1] == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r   <= '0;
      mcand_r <= a;
      mplr_r  <= b;
    end else if (busy_r) begin
      acc_r   <= mplr_r[0] ? (acc_r + mcand_r) : acc_r;
      mcand_r <= {mcand_r[P_W-2:0], 1'b0};
      mplr_r  <= {1'b0, mplr_r[M_W-1:1]};
    end
  end

  assign prod = acc_r;
  assign done = done_r;

  `OTSU_ASSERT_NOW(a_start_idle, clk, rst_n, start, !busy_r)
  `OTSU_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r)

endmodule
`default_nettype wire

@@ verif/otsu_threshold_binarizer_test.sv @@
// Self-checking testbench for the Otsu threshold binarizer.
`timescale 1ns / 1ps
module otsu_threshold_binarizer_test;
  import otsu_pkg::*;

  localparam int CNT_BITS = COUNT_BITS_DEF;
  localparam longint CNT_MAX = (64'd1 << CNT_BITS) - 1;
  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic       opcode;
    logic [7:0] luma;
    logic       last;
  } pix_req_t;

  typedef struct {
    logic [7:0] pixel_out;
    logic [7:0] threshold;
    logic       is_threshold;
  } pix_res_t;

  // directed row: request plus an optional typed-in result
  typedef struct {
    pix_req_t req;
    bit       typed;
    pix_res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  otsu_in_if  in_ch ();
  otsu_out_if out_ch ();

  otsu_threshold_binarizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint     hist_cnt [256];
  logic [7:0] cur_thr;

  pix_req_t send_q [$];
  bit       typed_q [$];
  pix_res_t typed_res_q [$];
  pix_res_t expected_q [$];
  int       fails = 0;
  bit       send_done = 0;
  int       idle_cycles = 0;
  bit       hold_long = 0;

  // exact variance comparison: d2a*pb > d2b*pa with 256-bit products
  function automatic logic [7:0] otsu_sweep();
    longint n_all, s_all, n0, s0, n1, s1;
    logic [127:0] d, d2, prod, best_d2, best_prod;
    logic [255:0] x, y;
    bit have;
    logic [7:0] chosen;
    n_all = 0; s_all = 0; n0 = 0; s0 = 0; have = 0; chosen = 0;
    best_d2 = 0; best_prod = 0;
    for (int t = 0; t < 256; t++) begin
      n_all += hist_cnt[t];
      s_all += t * hist_cnt[t];
    end
    for (int t = 0; t < 256; t++) begin
      n0 += hist_cnt[t];
      s0 += t * hist_cnt[t];
      n1 = n_all - n0;
      s1 = s_all - s0;
      if (n0 == 0 || n1 == 0) continue;
      d = 128'(s1) * 128'(n0) - 128'(s0) * 128'(n1);
      d2 = d * d;
      prod = 128'(n0) * 128'(n1);
      if (!have) begin
        have = 1; best_d2 = d2; best_prod = prod; chosen = t[7:0];
      end else begin
        x = 256'(d2) * 256'(best_prod);
        y = 256'(best_d2) * 256'(prod);
        if (x > y) begin
          best_d2 = d2; best_prod = prod; chosen = t[7:0];
        end
      end
    end
    return chosen;
  endfunction

  function automatic bit predict_pixel(pix_req_t r, output pix_res_t res);
    res = '{PIX_LO, cur_thr, 1'b0};
    if (r.opcode == OP_BIN) begin
      res.pixel_out = (r.luma < cur_thr) ? PIX_LO : PIX_HI;
      return 1;
    end
    if (hist_cnt[r.luma] < CNT_MAX) hist_cnt[r.luma]++;
    if (!r.last) return 0;
    cur_thr = otsu_sweep();
    foreach (hist_cnt[i]) hist_cnt[i] = 0;
    res = '{PIX_LO, cur_thr, 1'b1};
    return 1;
  endfunction

  task automatic queue_req(logic op, logic [7:0] l, logic lst);
    send_q.push_back('{op, l, lst});
    typed_q.push_back(0);
    typed_res_q.push_back('{PIX_LO, PIX_LO, 1'b0});
  endtask

  task automatic queue_row(row_t r);
    send_q.push_back(r.req);
    typed_q.push_back(r.typed);
    typed_res_q.push_back(r.res);
  endtask

  // random frame: few distinct values, sometimes wide spread
  task automatic queue_frame();
    int n, k;
    logic [7:0] base [4];
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
    k = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) base[i] = 8'($urandom);
    for (int i = 0; i < n; i++)
      queue_req(OP_ACC, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                base[$urandom_range(0, k - 1)], i == n - 1);
  endtask

  // sender
  initial begin
    row_t rows [$];
    pix_req_t r;
    int gap;
    in_ch.valid = 0; in_ch.opcode = 0; in_ch.luma = 0; in_ch.last = 0;
    foreach (hist_cnt[i]) hist_cnt[i] = 0;
    cur_thr = 0;
    // after reset threshold is 0: every luma passes high
    rows.push_back('{'{OP_BIN, 8'h00, 1'b0}, 1, '{PIX_HI, 8'h00, 1'b0}});
    rows.push_back('{'{OP_BIN, 8'hFF, 1'b1}, 1, '{PIX_HI, 8'h00, 1'b0}});
    // empty-ish histogram: single value gives threshold 0
    rows.push_back('{'{OP_ACC, 8'hFF, 1'b1}, 1, '{PIX_LO, 8'h00, 1'b1}});
    rows.push_back('{'{OP_ACC, 8'h00, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_ACC, 8'h00, 1'b1}, 1, '{PIX_LO, 8'h00, 1'b1}});
    // extremes 0 and 255: split at 0
    rows.push_back('{'{OP_ACC, 8'h00, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_ACC, 8'hFF, 1'b1}, 1, '{PIX_LO, 8'h00, 1'b1}});
    rows.push_back('{'{OP_ACC, 8'h10, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_ACC, 8'h10, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_ACC, 8'h80, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_ACC, 8'hF0, 1'b1}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_BIN, 8'h00, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_BIN, 8'h7F, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_BIN, 8'h80, 1'b1}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_BIN, 8'hFF, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_ACC, 8'hFE, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_ACC, 8'h01, 1'b1}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_BIN, 8'h01, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    rows.push_back('{'{OP_BIN, 8'h02, 1'b0}, 0, '{PIX_LO, 8'h00, 1'b0}});
    foreach (rows[i]) queue_row(rows[i]);
    // bin saturation run: one value repeated past the count limit is too slow,
    // so no frame reaches the count limit; random part follows
    while (send_q.size() < 1300) begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 20))
          queue_req(OP_BIN, 8'($urandom), 1'($urandom));
      else
        queue_frame();
    end
    // long burst of binarize requests for the receiver hold-off
    repeat (40) queue_req(OP_BIN, 8'($urandom), 1'($urandom));

    @(posedge clk);
    @(posedge clk);
    rst_n <= 1'b1;
    while (send_q.size() > 0) begin
      r = send_q.pop_front();
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (send_q.size() < 40) gap = 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.opcode <= r.opcode;
      in_ch.luma <= r.luma;
      in_ch.last <= r.last;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      // accepted at this edge
      begin
        pix_res_t res;
        bit typed;
        pix_res_t tres;
        typed = typed_q.pop_front();
        tres = typed_res_q.pop_front();
        if (predict_pixel(r, res)) expected_q.push_back(typed ? tres : res);
      end
      if (send_q.size() == 35) hold_long = 1;
    end
    in_ch.valid <= 1'b0;
    send_done = 1;
  end

  // receiver
  initial begin
    int wait_n;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        hold_long = 0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    pix_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result");
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.pixel_out !== e.pixel_out) begin
          $error("pixel_out expected %0d actual %0d", e.pixel_out, out_ch.pixel_out);
          fails++;
        end
        if (out_ch.threshold !== e.threshold) begin
          $error("threshold expected %0d actual %0d", e.threshold, out_ch.threshold);
          fails++;
        end
        if (out_ch.is_threshold !== e.is_threshold) begin
          $error("is_threshold expected %0d actual %0d", e.is_threshold,
                 out_ch.is_threshold);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("otsu_threshold_binarizer_test NOT OK");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (send_done);
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0)
      $display("otsu_threshold_binarizer_test OK");
    else
      $display("otsu_threshold_binarizer_test NOT OK");
    $finish;
  end

endmodule

@@ otsu_threshold_binarizer.f @@
+incdir+rtl/core
rtl/core/otsu_pkg.sv
rtl/core/otsu_in_if.sv
rtl/core/otsu_out_if.sv
rtl/core/otsu_hist_mem.sv
rtl/core/otsu_mul.sv
rtl/core/otsu_threshold_binarizer.sv
verif/otsu_threshold_binarizer_test.sv
